// File: rtl/te2q_pkg.sv
// shared types, constants and arithmetic helpers for the tilt euler to quaternion block
// no dependencies
package te2q_pkg;

	// datapath widths
	localparam int VEC_W      = 28;   // vectoring x/y, operands scaled by 2^8 plus growth
	localparam int ROT_W      = 34;   // rotation x/y/z
	localparam int SQ_W       = 48;   // square-root radicand
	localparam int SQRT_STEPS = 24;   // one result bit per cell
	localparam int TAB_LEN    = 24;
	localparam int LANES      = 3;    // roll, pitch, yaw

	// lane codes
	localparam int LANE_ROLL  = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_YAW   = 2;

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [ROT_W-1:0] rot_t;
	typedef logic signed [15:0]      angle_t;
	typedef logic signed [31:0]      q30_t;

	// atan(2^-i), 2^31 = pi
	localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	// 1/K in Q30
	localparam rot_t INV_GAIN = 34'sd652032874;

	// arctangent entry rounded half-up to an ab-bit binary angle
	function automatic logic [31:0] atan_bam(input int i, input int ab);
		logic [32:0] t;
		t = {1'b0, ATAN_TAB[i]} + (33'd1 << (31 - ab));
		return 32'(t >> (32 - ab));
	endfunction

	// q30 product rounded half-up
	function automatic q30_t mulq(input q30_t a, input q30_t b);
		logic signed [63:0] p;
		p = a * b + 64'sd536870912;
		return p[61:30];
	endfunction

	// round q30 sum to q1.14 and saturate to +-1.0
	function automatic angle_t to_q14(input logic signed [32:0] v);
		logic signed [32:0] r;
		r = (v + 33'sd32768) >>> 16;
		if (r > 33'sd16384)
			return 16'sd16384;
		else if (r < -33'sd16384)
			return -16'sd16384;
		else
			return r[15:0];
	endfunction

endpackage

// File: rtl/te2q_sqrt_cell.sv
// one restoring square-root cell: settles one result bit per clock while en is high
// uses te2q_pkg
module te2q_sqrt_cell #(
	parameter int Step = 0
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [te2q_pkg::SQ_W-1:0] rem_in,
	input  logic [te2q_pkg::SQ_W-1:0] res_in,
	output logic [te2q_pkg::SQ_W-1:0] rem_q,
	output logic [te2q_pkg::SQ_W-1:0] res_q
);

	localparam logic [te2q_pkg::SQ_W-1:0] Bit = te2q_pkg::SQ_W'(1) << (46 - 2 * Step);

	logic [te2q_pkg::SQ_W-1:0] trial;

	assign trial = res_in + Bit;

	// compare and subtract
	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_in >= trial) begin
				rem_q <= rem_in - trial;
				res_q <= (res_in >> 1) + Bit;
			end else begin
				rem_q <= rem_in;
				res_q <= res_in >> 1;
			end
		end
	end

endmodule

// File: rtl/te2q_vec_cell.sv
// one vectoring cordic micro-rotation with binary angle accumulation
// uses te2q_pkg
module te2q_vec_cell #(
	parameter int AngleBits = 16,
	parameter int Step      = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  te2q_pkg::vec_t       x_in,
	input  te2q_pkg::vec_t       y_in,
	input  logic [AngleBits-1:0] acc_in,
	output te2q_pkg::vec_t       x_q,
	output te2q_pkg::vec_t       y_q,
	output logic [AngleBits-1:0] acc_q
);

	localparam logic [AngleBits-1:0] Atan = AngleBits'(te2q_pkg::atan_bam(Step, AngleBits));

	// drive y towards zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[te2q_pkg::VEC_W-1]) begin
				x_q   <= x_in + (y_in >>> Step);
				y_q   <= y_in - (x_in >>> Step);
				acc_q <= acc_in + Atan;
			end else begin
				x_q   <= x_in - (y_in >>> Step);
				y_q   <= y_in + (x_in >>> Step);
				acc_q <= acc_in - Atan;
			end
		end
	end

endmodule

// File: rtl/te2q_rot_cell.sv
// one rotation cordic micro-rotation, residual angle in units of 2^31 = pi
// uses te2q_pkg
module te2q_rot_cell #(
	parameter int Step = 0
) (
	input  logic           clk,
	input  logic           en,
	input  te2q_pkg::rot_t x_in,
	input  te2q_pkg::rot_t y_in,
	input  te2q_pkg::rot_t z_in,
	output te2q_pkg::rot_t x_q,
	output te2q_pkg::rot_t y_q,
	output te2q_pkg::rot_t z_q
);

	localparam te2q_pkg::rot_t Atan = $signed({2'b00, te2q_pkg::ATAN_TAB[Step]});

	// drive residual towards zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[te2q_pkg::ROT_W-1]) begin
				x_q <= x_in - (y_in >>> Step);
				y_q <= y_in + (x_in >>> Step);
				z_q <= z_in - Atan;
			end else begin
				x_q <= x_in + (y_in >>> Step);
				y_q <= y_in - (x_in >>> Step);
				z_q <= z_in + Atan;
			end
		end
	end

endmodule

// File: rtl/tilt_euler_to_quaternion_top.sv
// top level: accelerometer tilt and gyro heading to binary angles and a q1.14 quaternion
// uses te2q_pkg, te2q_sqrt_cell, te2q_vec_cell, te2q_rot_cell

// A fully pipelined datapath that takes one sample word per clock and returns one result
// word per clock while out_stall does not hold a result. Each sample passes through the
// row of stages: capture, squaring and radicand registers, 24 square-root cells
// for the pitch magnitude, a half-plane fold register, ROTATION_STEPS vectoring cells for
// the three angles, an angle register, ROTATION_STEPS rotation cells for the half-angle
// sines and cosines, and two multiplier stages plus an output register. The whole pipe
// advances together; when a result is held by out_stall, in_stall rises in the same cycle.
module tilt_euler_to_quaternion_top #(
	parameter int ANGLE_BITS     = 16,
	parameter int ROTATION_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);

	localparam int RS = ROTATION_STEPS;
	localparam int NS = te2q_pkg::SQRT_STEPS;
	localparam int NL = te2q_pkg::LANES;
	localparam int L  = 32 + 2 * RS;

	logic         en;
	logic [L-1:0] vld_q;

	// global advance
	assign en        = !(vld_q[L-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[L-1];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], in_valid};
		end
	end

	// input, squares and radicand
	logic signed [15:0] ax_s1, ay_s1, az_s1, gx_s1, gy_s1;
	logic signed [15:0] ax_s2, ay_s2, az_s2, gx_s2, gy_s2;
	logic        [30:0] sqy_s2, sqz_s2;
	logic signed [31:0] pyy, pzz;

	assign pyy = ay_s1 * ay_s1;
	assign pzz = az_s1 * az_s1;

	logic signed [15:0]             ax_q [0:NS];
	logic signed [15:0]             ay_q [0:NS];
	logic signed [15:0]             az_q [0:NS];
	logic signed [15:0]             gx_q [0:NS];
	logic signed [15:0]             gy_q [0:NS];
	logic [te2q_pkg::SQ_W-1:0]      rem_w [0:NS];
	logic [te2q_pkg::SQ_W-1:0]      res_w [0:NS];
	logic [te2q_pkg::SQ_W-1:0]      rem_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= accel_x;
			ay_s1  <= accel_y;
			az_s1  <= accel_z;
			gx_s1  <= rate_x;
			gy_s1  <= rate_y;
			sqy_s2 <= pyy[30:0];
			sqz_s2 <= pzz[30:0];
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			az_s2  <= az_s1;
			gx_s2  <= gx_s1;
			gy_s2  <= gy_s1;
			rem_s3 <= te2q_pkg::SQ_W'({1'b0, sqy_s2} + {1'b0, sqz_s2}) << 16;
			ax_q[0] <= ax_s2;
			ay_q[0] <= ay_s2;
			az_q[0] <= az_s2;
			gx_q[0] <= gx_s2;
			gy_q[0] <= gy_s2;
			for (int k = 0; k < NS; k++) begin
				ax_q[k+1] <= ax_q[k];
				ay_q[k+1] <= ay_q[k];
				az_q[k+1] <= az_q[k];
				gx_q[k+1] <= gx_q[k];
				gy_q[k+1] <= gy_q[k];
			end
		end
	end

	assign rem_w[0] = rem_s3;
	assign res_w[0] = '0;

	// square-root cells
	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		te2q_sqrt_cell #(.Step(k)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_in (rem_w[k]),
			.res_in (res_w[k]),
			.rem_q  (rem_w[k+1]),
			.res_q  (res_w[k+1])
		);
	end

	// vectoring operands per lane
	te2q_pkg::vec_t px [NL];
	te2q_pkg::vec_t py [NL];

	always_comb begin
		py[te2q_pkg::LANE_ROLL]  = te2q_pkg::vec_t'(ay_q[NS]) <<< 8;
		px[te2q_pkg::LANE_ROLL]  = te2q_pkg::vec_t'(az_q[NS]) <<< 8;
		py[te2q_pkg::LANE_PITCH] = -(te2q_pkg::vec_t'(ax_q[NS]) <<< 8);
		px[te2q_pkg::LANE_PITCH] = $signed({4'b0000, res_w[NS][23:0]});
		py[te2q_pkg::LANE_YAW]   = te2q_pkg::vec_t'(gy_q[NS]) <<< 8;
		px[te2q_pkg::LANE_YAW]   = te2q_pkg::vec_t'(gx_q[NS]) <<< 8;
	end

	te2q_pkg::vec_t          vx  [NL][0:RS];
	te2q_pkg::vec_t          vy  [NL][0:RS];
	logic [ANGLE_BITS-1:0]   va  [NL][0:RS];
	logic                    zf_q [NL][0:RS];
	te2q_pkg::vec_t          fx_q [NL];
	te2q_pkg::vec_t          fy_q [NL];
	logic [ANGLE_BITS-1:0]   fa_q [NL];

	// half-plane fold and zero-vector flag
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				if (px[l][te2q_pkg::VEC_W-1]) begin
					fx_q[l] <= -px[l];
					fy_q[l] <= -py[l];
					fa_q[l] <= {1'b1, {(ANGLE_BITS-1){1'b0}}};
				end else begin
					fx_q[l] <= px[l];
					fy_q[l] <= py[l];
					fa_q[l] <= '0;
				end
				zf_q[l][0] <= (px[l] == '0) && (py[l] == '0);
				for (int i = 0; i < RS; i++)
					zf_q[l][i+1] <= zf_q[l][i];
			end
		end
	end

	// vectoring cells
	for (genvar l = 0; l < NL; l++) begin : g_vlane
		assign vx[l][0] = fx_q[l];
		assign vy[l][0] = fy_q[l];
		assign va[l][0] = fa_q[l];
		for (genvar i = 0; i < RS; i++) begin : g_vcell
			te2q_vec_cell #(.AngleBits(ANGLE_BITS), .Step(i)) u_cell (
				.clk    (clk),
				.en     (en),
				.x_in   (vx[l][i]),
				.y_in   (vy[l][i]),
				.acc_in (va[l][i]),
				.x_q    (vx[l][i+1]),
				.y_q    (vy[l][i+1]),
				.acc_q  (va[l][i+1])
			);
		end
	end

	// angle to 16 bits
	te2q_pkg::angle_t rnd [NL];

	for (genvar l = 0; l < NL; l++) begin : g_rnd
		if (ANGLE_BITS > 16) begin : g_wide
			logic [ANGLE_BITS-1:0] t;
			assign t      = va[l][RS] + (ANGLE_BITS'(1) << (ANGLE_BITS - 17));
			assign rnd[l] = t[ANGLE_BITS-1 -: 16];
		end else if (ANGLE_BITS == 16) begin : g_same
			assign rnd[l] = va[l][RS];
		end else begin : g_narrow
			assign rnd[l] = {va[l][RS], {(16-ANGLE_BITS){1'b0}}};
		end
	end

	te2q_pkg::angle_t ang_q [NL][0:RS];
	te2q_pkg::rot_t   rx [NL][0:RS];
	te2q_pkg::rot_t   ry [NL][0:RS];
	te2q_pkg::rot_t   rz [NL][0:RS];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				ang_q[l][0] <= zf_q[l][RS] ? '0 : rnd[l];
				for (int i = 0; i < RS; i++)
					ang_q[l][i+1] <= ang_q[l][i];
			end
		end
	end

	// rotation cells, half angle theta*pi/65536
	for (genvar l = 0; l < NL; l++) begin : g_rlane
		assign rx[l][0] = te2q_pkg::INV_GAIN;
		assign ry[l][0] = '0;
		assign rz[l][0] = te2q_pkg::rot_t'($signed({ang_q[l][0], 15'b0}));
		for (genvar i = 0; i < RS; i++) begin : g_rcell
			te2q_rot_cell #(.Step(i)) u_cell (
				.clk  (clk),
				.en   (en),
				.x_in (rx[l][i]),
				.y_in (ry[l][i]),
				.z_in (rz[l][i]),
				.x_q  (rx[l][i+1]),
				.y_q  (ry[l][i+1]),
				.z_q  (rz[l][i+1])
			);
		end
	end

	te2q_pkg::q30_t cr, sr, cp, sp, cy, sy;

	assign cr = rx[te2q_pkg::LANE_ROLL][RS][31:0];
	assign sr = ry[te2q_pkg::LANE_ROLL][RS][31:0];
	assign cp = rx[te2q_pkg::LANE_PITCH][RS][31:0];
	assign sp = ry[te2q_pkg::LANE_PITCH][RS][31:0];
	assign cy = rx[te2q_pkg::LANE_YAW][RS][31:0];
	assign sy = ry[te2q_pkg::LANE_YAW][RS][31:0];

	// roll and pitch products
	te2q_pkg::q30_t   srcp_s1, crsp_s1, crcp_s1, srsp_s1, cy_s1, sy_s1;
	te2q_pkg::angle_t roll_s1, pitch_s1, yaw_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			srcp_s1  <= te2q_pkg::mulq(sr, cp);
			crsp_s1  <= te2q_pkg::mulq(cr, sp);
			crcp_s1  <= te2q_pkg::mulq(cr, cp);
			srsp_s1  <= te2q_pkg::mulq(sr, sp);
			cy_s1    <= cy;
			sy_s1    <= sy;
			roll_s1  <= ang_q[te2q_pkg::LANE_ROLL][RS];
			pitch_s1 <= ang_q[te2q_pkg::LANE_PITCH][RS];
			yaw_s1   <= ang_q[te2q_pkg::LANE_YAW][RS];
		end
	end

	// yaw products
	te2q_pkg::q30_t   xa_s2, xb_s2, ya_s2, yb_s2, za_s2, zb_s2, wa_s2, wb_s2;
	te2q_pkg::angle_t roll_s2, pitch_s2, yaw_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			xa_s2    <= te2q_pkg::mulq(srcp_s1, cy_s1);
			xb_s2    <= te2q_pkg::mulq(crsp_s1, sy_s1);
			ya_s2    <= te2q_pkg::mulq(crsp_s1, cy_s1);
			yb_s2    <= te2q_pkg::mulq(srcp_s1, sy_s1);
			za_s2    <= te2q_pkg::mulq(crcp_s1, sy_s1);
			zb_s2    <= te2q_pkg::mulq(srsp_s1, cy_s1);
			wa_s2    <= te2q_pkg::mulq(crcp_s1, cy_s1);
			wb_s2    <= te2q_pkg::mulq(srsp_s1, sy_s1);
			roll_s2  <= roll_s1;
			pitch_s2 <= pitch_s1;
			yaw_s2   <= yaw_s1;
		end
	end

	// combine, round and saturate into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			quat_x      <= te2q_pkg::to_q14(33'(xa_s2) - 33'(xb_s2));
			quat_y      <= te2q_pkg::to_q14(33'(ya_s2) + 33'(yb_s2));
			quat_z      <= te2q_pkg::to_q14(33'(za_s2) - 33'(zb_s2));
			quat_w      <= te2q_pkg::to_q14(33'(wa_s2) + 33'(wb_s2));
			roll_angle  <= roll_s2;
			pitch_angle <= pitch_s2;
			yaw_angle   <= yaw_s2;
		end
	end

	// a taken word enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[0])
		else $error("accepted word did not enter the pipe");

	// a held pipe keeps every valid bit
	a_hold_all: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_q))
		else $error("pipe moved while held");

	// quaternion w and x components stay within +-1.0
	a_quat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quat_w <= 16'sd16384 && quat_w >= -16'sd16384
			&& quat_x <= 16'sd16384 && quat_x >= -16'sd16384)
		else $error("quaternion component out of range");

endmodule
